[sv/cfd_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the CAN filter bank.
package cfd_pkg;

  localparam int unsigned ID_W          = 29;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned NUM_SLOTS_DEF = 8;
  localparam int unsigned MAX_RESULTS   = 8;
  localparam int unsigned RES_W         = $clog2(MAX_RESULTS + 1);

  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_FRAME    = 1'b1;

  localparam logic ANS_REGISTER = 1'b0;
  localparam logic ANS_DELIVERY = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic capture;       // latch input transaction, restart scan
    logic idx_inc;       // step the free-slot search
    logic slot_write;    // store filter at scan index
    logic advance;       // step the frame compare pipeline
    logic push;          // load output register
    logic push_sel_pend; // delivery from pending match, else registration answer
    logic push_full;     // registration answer reports no free slot
    logic push_last;
  } cfd_cmd_t;

  typedef struct packed {
    logic idx_used;
    logic idx_at_end;
    logic issue_done;
    logic cmp_valid;
    logic cmp_match;
    logic pend_valid;
    logic cnt_reached;
    logic out_free;
  } cfd_stat_t;

endpackage

[sv/cfd_ctrl.sv]
// Sequencer for registration search and frame compare scan.
module cfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  input  logic              in_extended_flag_i,
  input  logic              in_remote_flag_i,
  output logic              in_stall_o,
  input  cfd_pkg::cfd_stat_t stat_i,
  output cfd_pkg::cfd_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REG,
    S_FRM,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  logic   accept;
  logic   need_push;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = stall_q;
  assign need_push  = stat_i.cmp_valid && stat_i.cmp_match && stat_i.pend_valid;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (in_kind_i == cfd_pkg::KIND_REGISTER) begin
            state_d = S_REG;
          end else if (in_extended_flag_i && !in_remote_flag_i) begin
            state_d = S_FRM;
          end
        end
      end
      S_REG: begin
        if (!stat_i.idx_used) begin
          if (stat_i.out_free) begin
            cmd_o.slot_write = 1'b1;
            cmd_o.push       = 1'b1;
            cmd_o.push_last  = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (stat_i.idx_at_end) begin
          if (stat_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_full = 1'b1;
            cmd_o.push_last = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_FRM: begin
        if (stat_i.cnt_reached) begin
          state_d = S_FLUSH;
        end else if (stat_i.issue_done && !stat_i.cmp_valid) begin
          state_d = stat_i.pend_valid ? S_FLUSH : S_IDLE;
        end else if (!need_push || stat_i.out_free) begin
          // emit the older match once a newer one shows it was not the last
          cmd_o.advance       = 1'b1;
          cmd_o.push          = need_push;
          cmd_o.push_sel_pend = 1'b1;
        end
      end
      S_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push          = 1'b1;
          cmd_o.push_sel_pend = 1'b1;
          cmd_o.push_last     = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != S_IDLE);
    end
  end

endmodule

[sv/cfd_datapath.sv]
// Filter store, slot index, compare stage, pending match and output register.
module cfd_datapath #(
  parameter int unsigned NUM_SLOTS = cfd_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cfd_pkg::ID_W-1:0]    in_filter_value_i,
  input  logic [cfd_pkg::ID_W-1:0]    in_filter_mask_i,
  input  logic [cfd_pkg::ID_W-1:0]    in_frame_id_i,
  input  logic [cfd_pkg::LEN_W-1:0]   in_frame_length_i,
  input  logic [cfd_pkg::DATA_W-1:0]  in_frame_data_i,
  input  cfd_pkg::cfd_cmd_t           cmd_i,
  output cfd_pkg::cfd_stat_t          stat_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_answer_kind_o,
  output logic                        out_status_o,
  output logic [cfd_pkg::SLOT_W-1:0]  out_slot_o,
  output logic [cfd_pkg::ID_W-1:0]    out_delivered_id_o,
  output logic [cfd_pkg::LEN_W-1:0]   out_delivered_length_o,
  output logic [cfd_pkg::DATA_W-1:0]  out_delivered_data_o,
  output logic                        out_last_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned ENT_W = 2 * cfd_pkg::ID_W;

  // captured transaction
  logic [cfd_pkg::ID_W-1:0]   fval_q, fmask_q, fid_q;
  logic [cfd_pkg::LEN_W-1:0]  flen_q;
  logic [cfd_pkg::DATA_W-1:0] fdata_q;

  // filter store: value in the upper half, mask in the lower half
  logic [ENT_W-1:0] mem_q [NUM_SLOTS];
  logic [ENT_W-1:0] rd_q;
  logic             rd_en;
  logic [IDX_W-1:0] idx;

  logic [NUM_SLOTS-1:0]       used_q;
  logic [CNT_W-1:0]           idx_q;
  logic                       cmp_vld_q;
  logic [IDX_W-1:0]           cmp_idx_q;
  logic                       pend_vld_q;
  logic [IDX_W-1:0]           pend_idx_q;
  logic [cfd_pkg::RES_W-1:0]  res_cnt_q;
  logic                       issue_done;
  logic                       match;
  logic                       out_free;

  logic                       out_vld_q;
  logic                       o_kind_q, o_status_q, o_last_q;
  logic [cfd_pkg::SLOT_W-1:0] o_slot_q;
  logic [cfd_pkg::ID_W-1:0]   o_id_q;
  logic [cfd_pkg::LEN_W-1:0]  o_len_q;
  logic [cfd_pkg::DATA_W-1:0] o_data_q;

  assign idx        = idx_q[IDX_W-1:0];
  assign issue_done = (idx_q == CNT_W'(NUM_SLOTS));
  assign rd_en      = cmd_i.advance && !issue_done;
  assign match      = cmp_vld_q && used_q[cmp_idx_q] &&
                      ((fid_q & rd_q[cfd_pkg::ID_W-1:0]) == rd_q[ENT_W-1:cfd_pkg::ID_W]);
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    stat_o             = '0;
    stat_o.idx_used    = used_q[idx];
    stat_o.idx_at_end  = (idx_q == CNT_W'(NUM_SLOTS - 1));
    stat_o.issue_done  = issue_done;
    stat_o.cmp_valid   = cmp_vld_q;
    stat_o.cmp_match   = match;
    stat_o.pend_valid  = pend_vld_q;
    stat_o.cnt_reached = (res_cnt_q == cfd_pkg::RES_W'(cfd_pkg::MAX_RESULTS));
    stat_o.out_free    = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fval_q  <= in_filter_value_i;
      fmask_q <= in_filter_mask_i;
      fid_q   <= in_frame_id_i;
      flen_q  <= in_frame_length_i;
      fdata_q <= in_frame_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_write) begin
      mem_q[idx] <= {fval_q, fmask_q};
    end
    if (rd_en) begin
      rd_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      idx_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      pend_vld_q <= 1'b0;
      pend_idx_q <= '0;
      res_cnt_q  <= '0;
    end else begin
      if (cmd_i.slot_write) begin
        used_q[idx] <= 1'b1;
      end
      if (cmd_i.capture) begin
        idx_q      <= '0;
        cmp_vld_q  <= 1'b0;
        pend_vld_q <= 1'b0;
        res_cnt_q  <= '0;
      end else begin
        if (cmd_i.idx_inc || rd_en) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (cmd_i.advance) begin
          cmp_vld_q <= !issue_done;
          cmp_idx_q <= idx;
        end
        if (cmd_i.advance && match) begin
          pend_vld_q <= 1'b1;
          pend_idx_q <= cmp_idx_q;
          res_cnt_q  <= res_cnt_q + cfd_pkg::RES_W'(1);
        end else if (cmd_i.push && cmd_i.push_sel_pend) begin
          pend_vld_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      o_last_q <= cmd_i.push_last;
      if (cmd_i.push_sel_pend) begin
        o_kind_q   <= cfd_pkg::ANS_DELIVERY;
        o_status_q <= cfd_pkg::STATUS_OK;
        o_slot_q   <= cfd_pkg::SLOT_W'(pend_idx_q);
        o_id_q     <= fid_q;
        o_len_q    <= flen_q;
        o_data_q   <= fdata_q;
      end else begin
        o_kind_q   <= cfd_pkg::ANS_REGISTER;
        o_status_q <= cmd_i.push_full ? cfd_pkg::STATUS_FULL : cfd_pkg::STATUS_OK;
        o_slot_q   <= cmd_i.push_full ? '0 : cfd_pkg::SLOT_W'(idx);
        o_id_q     <= '0;
        o_len_q    <= '0;
        o_data_q   <= '0;
      end
    end
  end

  assign out_valid_o            = out_vld_q;
  assign out_answer_kind_o      = o_kind_q;
  assign out_status_o           = o_status_q;
  assign out_slot_o             = o_slot_q;
  assign out_delivered_id_o     = o_id_q;
  assign out_delivered_length_o = o_len_q;
  assign out_delivered_data_o   = o_data_q;
  assign out_last_o             = o_last_q;

endmodule

[sv/can_id_mask_filter_dispatch.sv]
// Top level of the extended-frame acceptance filter bank.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | kind, filter pair, frame id/flags/len/data
//  out     | output    | out_valid_o/out_stall_i | answer kind, status, slot, frame, last
//
// A registration searches one slot per cycle for the lowest free slot. A frame
// reads one filter per cycle from the store (one read port, registered data),
// held while an older match waits on a stalled output. Dropped frames (not
// extended, or remote) get no answer. Reset clears the slot-used bits; the store is not
// cleared. The output register lets a new transaction enter while a result waits.
module can_id_mask_filter_dispatch #(
  parameter int unsigned NUM_SLOTS = cfd_pkg::NUM_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        in_kind_i,
  input  logic [cfd_pkg::ID_W-1:0]    in_filter_value_i,
  input  logic [cfd_pkg::ID_W-1:0]    in_filter_mask_i,
  input  logic [cfd_pkg::ID_W-1:0]    in_frame_id_i,
  input  logic                        in_extended_flag_i,
  input  logic                        in_remote_flag_i,
  input  logic [cfd_pkg::LEN_W-1:0]   in_frame_length_i,
  input  logic [cfd_pkg::DATA_W-1:0]  in_frame_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_answer_kind_o,
  output logic                        out_status_o,
  output logic [cfd_pkg::SLOT_W-1:0]  out_slot_o,
  output logic [cfd_pkg::ID_W-1:0]    out_delivered_id_o,
  output logic [cfd_pkg::LEN_W-1:0]   out_delivered_length_o,
  output logic [cfd_pkg::DATA_W-1:0]  out_delivered_data_o,
  output logic                        out_last_o
);

  cfd_pkg::cfd_cmd_t  cmd;
  cfd_pkg::cfd_stat_t stat;

  cfd_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_kind_i          (in_kind_i),
    .in_extended_flag_i (in_extended_flag_i),
    .in_remote_flag_i   (in_remote_flag_i),
    .in_stall_o         (in_stall_o),
    .stat_i             (stat),
    .cmd_o              (cmd)
  );

  cfd_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_filter_value_i      (in_filter_value_i),
    .in_filter_mask_i       (in_filter_mask_i),
    .in_frame_id_i          (in_frame_id_i),
    .in_frame_length_i      (in_frame_length_i),
    .in_frame_data_i        (in_frame_data_i),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_answer_kind_o      (out_answer_kind_o),
    .out_status_o           (out_status_o),
    .out_slot_o             (out_slot_o),
    .out_delivered_id_o     (out_delivered_id_o),
    .out_delivered_length_o (out_delivered_length_o),
    .out_delivered_data_o   (out_delivered_data_o),
    .out_last_o             (out_last_o)
  );

endmodule
